[design/twpf_pkg.sv]
// Shared types, sizes and codes for the time-window packet FIFO.
// Used by twpf_front, twpf_back and time_window_packet_fifo; no dependencies.
`default_nettype none

package twpf_pkg;

    localparam int DEPTH       = 64;
    localparam int MAX_RESULTS = 64;
    localparam int QDEPTH      = 2;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int EVN_W  = $clog2(MAX_RESULTS);
    localparam int CMP_W  = (OCC_W > CNT_W) ? OCC_W : CNT_W;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int TIME_W = 48;
    localparam int WORD_W = 32;
    localparam int DIFF_W = 23;

    // floor(x / 1000) = (x * DIV_MUL) >> DIV_SHIFT, exact for any 32-bit x
    localparam int DIV_MUL_W = 29;
    localparam int DIV_SHIFT = 38;
    localparam int PROD_W    = WORD_W + DIV_MUL_W;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL = 29'd274877907;

    localparam logic [WORD_W-1:0] WINDOW_RESET = 32'd1000000;

    localparam logic [1:0] KIND_EVICT  = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_DIFF   = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [OCC_W-1:0]  t_occ;
    typedef logic [OCC_W:0]    t_sum;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [EVN_W-1:0]  t_evn;
    typedef logic [CMP_W-1:0]  t_cmp;
    typedef logic [QPTR_W-1:0] t_qptr;
    typedef logic [QCNT_W-1:0] t_qcnt;
    typedef logic [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic              is_read;
        logic [TIME_W-1:0] time_us;
        logic [WORD_W-1:0] delay_us;
        logic [WORD_W-1:0] delay_new_us;
        logic [WORD_W-1:0] seq;
        t_cnt              count;
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0] time_us;
        logic [WORD_W-1:0] delay_us;
        logic [WORD_W-1:0] delay_new_us;
        logic [WORD_W-1:0] seq;
    } t_entry;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [TIME_W-1:0] time_us;
        logic [WORD_W-1:0] delay_us;
        logic [WORD_W-1:0] delay_new_us;
        logic [WORD_W-1:0] seq;
        logic [DIFF_W-1:0] diff_ms;
        logic              last;
    } t_result;

    // base + off modulo DEPTH, with off no larger than DEPTH
    function automatic t_addr wrap_add(input t_addr base, input t_occ off);
        t_sum sum;
        sum = t_sum'(base) + t_sum'(off);
        if (sum >= t_sum'(DEPTH)) begin
            sum = sum - t_sum'(DEPTH);
        end
        return t_addr'(sum);
    endfunction

endpackage

`default_nettype wire

[design/twpf_front.sv]
// Front end: takes requests, decodes them into commands and queues them.
// Depends on twpf_pkg.
`default_nettype none

module twpf_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_action,
    input  wire logic [47:0]            i_recv_time_us,
    input  wire logic [31:0]            i_oneway_us,
    input  wire logic [31:0]            i_oneway_new_us,
    input  wire logic [31:0]            i_seq,
    input  wire logic [6:0]             i_diff_count,
    output twpf_pkg::t_cmd              o_cmd,
    output logic                        o_cmd_valid,
    input  wire logic                   i_pop
);

    twpf_pkg::t_cmd  r_q [twpf_pkg::QDEPTH];
    twpf_pkg::t_qptr r_wr_ptr, n_wr_ptr;
    twpf_pkg::t_qptr r_rd_ptr, n_rd_ptr;
    twpf_pkg::t_qcnt r_count, n_count;
    twpf_pkg::t_cmd  cmd_in;
    logic            push;

    always_comb begin
        cmd_in.is_read      = i_action;
        cmd_in.time_us      = i_recv_time_us;
        cmd_in.delay_us     = i_oneway_us;
        cmd_in.delay_new_us = i_oneway_new_us;
        cmd_in.seq          = i_seq;
        // clamp the read count to the most results one request may give
        if (twpf_pkg::t_cmp'(i_diff_count) > twpf_pkg::t_cmp'(twpf_pkg::MAX_RESULTS)) begin
            cmd_in.count = twpf_pkg::t_cnt'(twpf_pkg::MAX_RESULTS);
        end else begin
            cmd_in.count = twpf_pkg::t_cnt'(i_diff_count);
        end
    end

    assign busy        = (r_count == twpf_pkg::t_qcnt'(twpf_pkg::QDEPTH));
    assign push        = start && !busy;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            if (r_wr_ptr == twpf_pkg::t_qptr'(twpf_pkg::QDEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + twpf_pkg::t_qptr'(1);
            end
        end
        if (i_pop) begin
            if (r_rd_ptr == twpf_pkg::t_qptr'(twpf_pkg::QDEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + twpf_pkg::t_qptr'(1);
            end
        end
        if (push && !i_pop) begin
            n_count = r_count + twpf_pkg::t_qcnt'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - twpf_pkg::t_qcnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty command queue");
`endif

endmodule

`default_nettype wire

[design/twpf_back.sv]
// Back end: record store, eviction walk and delay-difference walk.
// Depends on twpf_pkg; fed by twpf_front.
`default_nettype none

module twpf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [31:0]   i_cfg_data,
    input  wire twpf_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_pop,
    output logic               o_valid,
    output twpf_pkg::t_result  o_res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EV_RD  = 3'd1;
    localparam logic [2:0] S_EV_CHK = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_ABS    = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    twpf_pkg::t_entry  r_mem [twpf_pkg::DEPTH];
    twpf_pkg::t_entry  r_rd;

    logic [2:0]        r_state, n_state;
    twpf_pkg::t_addr   r_head, n_head;
    twpf_pkg::t_occ    r_occ, n_occ;
    logic [31:0]       r_window, n_window;
    logic [47:0]       r_newest, n_newest;
    twpf_pkg::t_evn    r_evn, n_evn;
    twpf_pkg::t_cnt    r_cnt, n_cnt;
    twpf_pkg::t_cnt    r_idx, n_idx;
    logic [31:0]       r_prev, n_prev;
    logic [31:0]       r_abs, n_abs;
    twpf_pkg::t_prod   r_prod, n_prod;
    logic              r_valid, n_valid;
    twpf_pkg::t_result r_res, n_res;

    logic              mem_we;
    twpf_pkg::t_addr   mem_waddr;
    twpf_pkg::t_entry  mem_wdata;
    logic              rd_en;
    twpf_pkg::t_addr   rd_addr;
    twpf_pkg::t_cnt    read_cnt;
    logic [47:0]       age;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    assign age = r_newest - r_rd.time_us;

    always_comb begin
        if (twpf_pkg::t_cmp'(i_cmd.count) > twpf_pkg::t_cmp'(r_occ)) begin
            read_cnt = twpf_pkg::t_cnt'(r_occ);
        end else begin
            read_cnt = i_cmd.count;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_occ     = r_occ;
        n_window  = r_window;
        n_newest  = r_newest;
        n_evn     = r_evn;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_prev    = r_prev;
        n_abs     = r_abs;
        n_prod    = r_prod;
        n_valid   = 1'b0;
        n_res     = '0;
        mem_we    = 1'b0;
        mem_waddr = twpf_pkg::wrap_add(r_head, r_occ);
        mem_wdata.time_us      = i_cmd.time_us;
        mem_wdata.delay_us     = i_cmd.delay_us;
        mem_wdata.delay_new_us = i_cmd.delay_new_us;
        mem_wdata.seq          = i_cmd.seq;
        rd_en     = 1'b0;
        rd_addr   = r_head;
        o_pop     = 1'b0;

        if (i_cfg_valid) begin
            n_window = i_cfg_data;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (!i_cmd.is_read) begin
                        if ((r_occ != '0) && (i_cmd.time_us < r_newest)) begin
                            n_valid      = 1'b1;
                            n_res.kind   = twpf_pkg::KIND_STATUS;
                            n_res.status = twpf_pkg::ST_ORDER;
                            n_res.last   = 1'b1;
                        end else if (r_occ == twpf_pkg::t_occ'(twpf_pkg::DEPTH)) begin
                            n_valid      = 1'b1;
                            n_res.kind   = twpf_pkg::KIND_STATUS;
                            n_res.status = twpf_pkg::ST_FULL;
                            n_res.last   = 1'b1;
                        end else begin
                            mem_we   = 1'b1;
                            n_occ    = r_occ + twpf_pkg::t_occ'(1);
                            n_newest = i_cmd.time_us;
                            n_evn    = '0;
                            if (r_occ == '0) begin
                                n_valid      = 1'b1;
                                n_res.kind   = twpf_pkg::KIND_STATUS;
                                n_res.status = twpf_pkg::ST_OK;
                                n_res.last   = 1'b1;
                            end else begin
                                n_state = S_EV_RD;
                            end
                        end
                    end else begin
                        if (read_cnt == '0) begin
                            n_valid    = 1'b1;
                            n_res.kind = twpf_pkg::KIND_EMPTY;
                            n_res.last = 1'b1;
                        end else begin
                            n_cnt   = read_cnt;
                            n_idx   = '0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_EV_RD: begin
                // always keep the newest entry; cap evictions per insert
                if ((r_occ > twpf_pkg::t_occ'(1))
                        && (r_evn != twpf_pkg::t_evn'(twpf_pkg::MAX_RESULTS - 1))) begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_state = S_EV_CHK;
                end else begin
                    n_valid      = 1'b1;
                    n_res.kind   = twpf_pkg::KIND_STATUS;
                    n_res.status = twpf_pkg::ST_OK;
                    n_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EV_CHK: begin
                if (age > {16'd0, r_window}) begin
                    n_valid            = 1'b1;
                    n_res.kind         = twpf_pkg::KIND_EVICT;
                    n_res.time_us      = r_rd.time_us;
                    n_res.delay_us     = r_rd.delay_us;
                    n_res.delay_new_us = r_rd.delay_new_us;
                    n_res.seq          = r_rd.seq;
                    n_head  = twpf_pkg::wrap_add(r_head, twpf_pkg::t_occ'(1));
                    n_occ   = r_occ - twpf_pkg::t_occ'(1);
                    n_evn   = r_evn + twpf_pkg::t_evn'(1);
                    n_state = S_EV_RD;
                end else begin
                    n_valid      = 1'b1;
                    n_res.kind   = twpf_pkg::KIND_STATUS;
                    n_res.status = twpf_pkg::ST_OK;
                    n_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                rd_en   = 1'b1;
                rd_addr = twpf_pkg::wrap_add(r_head, twpf_pkg::t_occ'(r_idx));
                n_state = S_ABS;
            end
            S_ABS: begin
                if (r_rd.delay_us >= r_prev) begin
                    n_abs = r_rd.delay_us - r_prev;
                end else begin
                    n_abs = r_prev - r_rd.delay_us;
                end
                n_prev  = r_rd.delay_us;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = twpf_pkg::t_prod'(r_abs) * twpf_pkg::t_prod'(twpf_pkg::DIV_MUL);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_valid       = 1'b1;
                n_res.kind    = twpf_pkg::KIND_DIFF;
                n_res.time_us = r_rd.time_us;
                if (r_idx != '0) begin
                    n_res.diff_ms = r_prod[twpf_pkg::DIV_SHIFT +: twpf_pkg::DIFF_W];
                end
                if ((r_idx + twpf_pkg::t_cnt'(1)) == r_cnt) begin
                    n_res.last = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_idx   = r_idx + twpf_pkg::t_cnt'(1);
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_occ    <= '0;
            r_window <= twpf_pkg::WINDOW_RESET;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_window <= n_window;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_newest <= n_newest;
        r_evn    <= n_evn;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_prev   <= n_prev;
        r_abs    <= n_abs;
        r_prod   <= n_prod;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= twpf_pkg::t_occ'(twpf_pkg::DEPTH))
        else $error("occupancy above depth");

    a_keep_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ != '0) |=> (r_occ != '0))
        else $error("store emptied by eviction");

    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_res.kind == twpf_pkg::KIND_EVICT)) |-> !r_res.last)
        else $error("evicted record marked last");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |->
            ((r_idx < r_cnt) && (twpf_pkg::t_cmp'(r_cnt) <= twpf_pkg::t_cmp'(r_occ))))
        else $error("read walk beyond stored entries");
`endif

endmodule

`default_nettype wire

[design/time_window_packet_fifo.sv]
// Time-window packet FIFO: request queue in front, record store in back.
// Each request goes through the queue register, is popped by the idle back
// end and its first result is registered; rejects, first inserts and empty
// reads give a single result. Each eviction adds a registered head read then
// an age compare; each read entry passes memory read, delay difference,
// multiply by reciprocal of 1000, output. busy rises when the two-request
// queue is full. Results are strobed for one cycle and cannot be stalled.
// Synchronous active-low reset empties store and queue, window to 1000000 us.
`default_nettype none

module time_window_packet_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic          i_action,
    input  wire logic [47:0]   i_recv_time_us,
    input  wire logic [31:0]   i_oneway_us,
    input  wire logic [31:0]   i_oneway_new_us,
    input  wire logic [31:0]   i_seq,
    input  wire logic [6:0]    i_diff_count,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [31:0]   i_cfg_data,
    output logic               o_valid,
    output logic [1:0]         o_kind,
    output logic [1:0]         o_status,
    output logic [47:0]        o_time_out_us,
    output logic [31:0]        o_delay_out_us,
    output logic [31:0]        o_delay_new_out_us,
    output logic [31:0]        o_seq_out,
    output logic [22:0]        o_diff_ms,
    output logic               o_last
);

    twpf_pkg::t_cmd    cmd;
    logic              cmd_valid;
    logic              pop;
    twpf_pkg::t_result res;

    twpf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_recv_time_us  (i_recv_time_us),
        .i_oneway_us     (i_oneway_us),
        .i_oneway_new_us (i_oneway_new_us),
        .i_seq           (i_seq),
        .i_diff_count    (i_diff_count),
        .o_cmd           (cmd),
        .o_cmd_valid     (cmd_valid),
        .i_pop           (pop)
    );

    twpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_res       (res)
    );

    assign o_kind             = res.kind;
    assign o_status           = res.status;
    assign o_time_out_us      = res.time_us;
    assign o_delay_out_us     = res.delay_us;
    assign o_delay_new_out_us = res.delay_new_us;
    assign o_seq_out          = res.seq;
    assign o_diff_ms          = res.diff_ms;
    assign o_last             = res.last;

endmodule

`default_nettype wire
